// ----- src/sixteen_bit_register_machine_core_unit_macros.svh -----
// Assertion macros used by the checker of the register machine core.
`ifndef SIXTEEN_BIT_REGISTER_MACHINE_CORE_UNIT_MACROS_SVH
`define SIXTEEN_BIT_REGISTER_MACHINE_CORE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define SRMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define SRMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/srmc_pkg.sv -----
// Types and constants of the sixteen-bit register machine core.
package srmc_pkg;

  localparam int WORD_W    = 16;
  localparam int ADDR_W    = 8;
  localparam int REG_IDX_W = 4;
  localparam int REG_COUNT = 16;

  localparam logic [ADDR_W-1:0] PC_LAST     = 8'hFF;
  localparam logic [ADDR_W-1:0] START_RESET = 8'h10;

  // Item modes.
  localparam logic [2:0] MODE_WRITE    = 3'd0;
  localparam logic [2:0] MODE_EXEC     = 3'd1;
  localparam logic [2:0] MODE_READ_REG = 3'd2;
  localparam logic [2:0] MODE_READ_MEM = 3'd3;
  localparam logic [2:0] MODE_RESTART  = 3'd4;

  // Opcodes.
  localparam logic [3:0] OP_HALT   = 4'h0;
  localparam logic [3:0] OP_ADD    = 4'h1;
  localparam logic [3:0] OP_SUB    = 4'h2;
  localparam logic [3:0] OP_AND    = 4'h3;
  localparam logic [3:0] OP_XOR    = 4'h4;
  localparam logic [3:0] OP_SHL    = 4'h5;
  localparam logic [3:0] OP_SRA    = 4'h6;
  localparam logic [3:0] OP_LDA    = 4'h7;
  localparam logic [3:0] OP_LOAD   = 4'h8;
  localparam logic [3:0] OP_STORE  = 4'h9;
  localparam logic [3:0] OP_LOADI  = 4'hA;
  localparam logic [3:0] OP_STOREI = 4'hB;
  localparam logic [3:0] OP_BZ     = 4'hC;
  localparam logic [3:0] OP_BP     = 4'hD;
  localparam logic [3:0] OP_JR     = 4'hE;
  localparam logic [3:0] OP_JAL    = 4'hF;

  // Stage at which an item is committed.
  localparam logic [1:0] STAGE_DECODE = 2'd0;
  localparam logic [1:0] STAGE_EXEC   = 2'd1;
  localparam logic [1:0] STAGE_MEM    = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0]    read_data;
    logic [ADDR_W-1:0]    pc_after;
    logic                 halted;
    logic                 reg_written;
    logic [REG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    reg_value;
    logic                 mem_written;
    logic [ADDR_W-1:0]    mem_address;
    logic [WORD_W-1:0]    mem_value;
  } result_t;

  typedef struct packed {
    logic       load_item;
    logic       clear;
    logic       fetch;
    logic       decode;
    logic       mem_read;
    logic       commit;
    logic [1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic exec_mode;
    logic halt_now;
    logic needs_mem;
    logic out_free;
  } status_t;

endpackage

// ----- src/srmc_stream_if.sv -----
// Valid/ready channel carrying one payload item.
interface srmc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- src/srmc_controller.sv -----
// Sequencer for clearing, fetch, decode, execute and memory stages.
module srmc_controller import srmc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_DECODE = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_MEM    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DECODE;
      end
      S_DECODE: begin
        if (status.exec_mode && !status.halt_now) begin
          cmd.decode = 1'b1;
          state_next = S_EXEC;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          cmd.stage  = STAGE_DECODE;
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        if (status.needs_mem) begin
          cmd.mem_read = 1'b1;
          state_next   = S_MEM;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          cmd.stage  = STAGE_EXEC;
          state_next = S_IDLE;
        end
      end
      S_MEM: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          cmd.stage  = STAGE_MEM;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/srmc_datapath.sv -----
// Register file, main memory, program counter, execute logic and result register.
module srmc_datapath import srmc_pkg::*; #(
  parameter int MEMORY_WORDS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  item_t             in_item,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_result
);

  localparam int AW    = $clog2(MEMORY_WORDS);
  localparam int LIM_W = ADDR_W + 1;
  localparam logic [LIM_W-1:0] MemLimit = LIM_W'(MEMORY_WORDS);
  localparam logic [AW-1:0]    ClearLast = AW'(MEMORY_WORDS - 1);

  function automatic logic in_range(input logic [ADDR_W-1:0] a);
    return {1'b0, a} < MemLimit;
  endfunction

  logic [WORD_W-1:0] mem [MEMORY_WORDS];
  logic [WORD_W-1:0] rf [REG_COUNT];

  logic [ADDR_W-1:0] start_address;
  logic [ADDR_W-1:0] pc;
  logic              stopped;
  item_t             item;
  logic [WORD_W-1:0] ir;
  logic [WORD_W-1:0] mem_q;
  logic              mem_ok_q;
  logic [WORD_W-1:0] rf_a_q;
  logic [WORD_W-1:0] rf_b_q;
  logic [AW-1:0]     clear_idx;

  logic [WORD_W-1:0]    mem_word;
  logic [3:0]           fetch_op;
  logic [3:0]           op;
  logic [ADDR_W-1:0]    mem_raddr;
  logic                 mem_ren;
  logic [REG_IDX_W-1:0] rf_a_addr;
  logic [REG_IDX_W-1:0] rf_b_addr;
  logic                 rf_ren;

  logic [ADDR_W-1:0]    pc_next;
  logic                 stopped_next;
  logic [ADDR_W-1:0]    pc_inc;
  logic [ADDR_W-1:0]    target;
  logic                 mw;
  logic [ADDR_W-1:0]    wa;
  logic [WORD_W-1:0]    wd;
  logic                 rw;
  logic [REG_IDX_W-1:0] ra;
  logic [WORD_W-1:0]    rv;
  logic [WORD_W-1:0]    read_val;
  result_t              res;

  assign mem_word = mem_ok_q ? mem_q : '0;
  assign fetch_op = mem_word[15:12];
  assign op       = ir[15:12];
  assign pc_inc   = pc + 8'd1;

  assign status.clear_last = (clear_idx == ClearLast);
  assign status.exec_mode  = (item.mode == MODE_EXEC);
  // Fetching beyond memory reads zero, which halts like a fetched halt opcode.
  assign status.halt_now   = stopped || (pc == PC_LAST) || (fetch_op == OP_HALT);
  assign status.needs_mem  = (op == OP_LOAD) || (op == OP_LOADI);
  assign status.out_free   = !out_valid || out_ready;

  // Read port addresses: the item address or program counter during fetch, then the operands of the instruction.
  always_comb begin
    if (cmd.fetch) begin
      mem_raddr = (item.mode == MODE_EXEC) ? pc : item.address;
    end else if (op == OP_LOADI) begin
      mem_raddr = rf_b_q[ADDR_W-1:0];
    end else begin
      mem_raddr = ir[ADDR_W-1:0];
    end
    mem_ren = cmd.fetch || cmd.mem_read;

    if (cmd.fetch) begin
      rf_a_addr = item.address[REG_IDX_W-1:0];
    end else if (fetch_op >= OP_ADD && fetch_op <= OP_SRA) begin
      rf_a_addr = mem_word[7:4];
    end else begin
      rf_a_addr = mem_word[11:8];
    end
    rf_b_addr = mem_word[3:0];
    rf_ren    = cmd.fetch || cmd.decode;
  end

  // Effects and result of the item being committed.
  always_comb begin
    pc_next      = pc;
    stopped_next = stopped;
    target       = pc_inc;
    mw           = 1'b0;
    wa           = item.address;
    wd           = item.data;
    rw           = 1'b0;
    ra           = ir[11:8];
    rv           = '0;
    read_val     = '0;
    case (item.mode)
      MODE_WRITE: begin
        mw = in_range(item.address);
      end
      MODE_READ_REG: begin
        read_val = (item.address[ADDR_W-1:REG_IDX_W] == '0) ? rf_a_q : '0;
      end
      MODE_READ_MEM: begin
        read_val = mem_word;
      end
      MODE_RESTART: begin
        pc_next      = start_address;
        stopped_next = (start_address == PC_LAST);
      end
      MODE_EXEC: begin
        if (cmd.stage == STAGE_DECODE) begin
          stopped_next = 1'b1;
        end else begin
          unique case (op) inside
            OP_ADD: begin
              rw = 1'b1;
              rv = rf_a_q + rf_b_q;
            end
            OP_SUB: begin
              rw = 1'b1;
              rv = rf_a_q - rf_b_q;
            end
            OP_AND: begin
              rw = 1'b1;
              rv = rf_a_q & rf_b_q;
            end
            OP_XOR: begin
              rw = 1'b1;
              rv = rf_a_q ^ rf_b_q;
            end
            OP_SHL: begin
              rw = 1'b1;
              rv = (rf_b_q[WORD_W-1:4] != '0) ? '0 : (rf_a_q << rf_b_q[3:0]);
            end
            OP_SRA: begin
              rw = 1'b1;
              rv = (rf_b_q[WORD_W-1:4] != '0) ? {WORD_W{rf_a_q[WORD_W-1]}}
                                              : WORD_W'($signed(rf_a_q) >>> rf_b_q[3:0]);
            end
            OP_LDA: begin
              rw = 1'b1;
              rv = {8'h00, ir[ADDR_W-1:0]};
            end
            OP_LOAD, OP_LOADI: begin
              rw = 1'b1;
              rv = mem_word;
            end
            OP_STORE: begin
              wa = ir[ADDR_W-1:0];
              wd = rf_a_q;
              mw = in_range(ir[ADDR_W-1:0]);
            end
            OP_STOREI: begin
              wa = rf_b_q[ADDR_W-1:0];
              wd = rf_a_q;
              mw = in_range(rf_b_q[ADDR_W-1:0]);
            end
            OP_BZ: begin
              if (rf_a_q == '0) target = ir[ADDR_W-1:0];
            end
            OP_BP: begin
              if (rf_a_q != '0 && !rf_a_q[WORD_W-1]) target = ir[ADDR_W-1:0];
            end
            OP_JR: begin
              target = rf_a_q[ADDR_W-1:0];
            end
            OP_JAL: begin
              rw     = 1'b1;
              rv     = {8'h00, pc_inc};
              target = ir[ADDR_W-1:0];
            end
            default: begin
            end
          endcase
          pc_next      = target;
          stopped_next = (target == PC_LAST);
        end
      end
      default: begin
      end
    endcase

    res             = '0;
    res.read_data   = read_val;
    res.pc_after    = pc_next;
    res.halted      = stopped_next;
    res.reg_written = rw;
    res.reg_index   = rw ? ra : '0;
    res.reg_value   = rw ? rv : '0;
    res.mem_written = mw;
    res.mem_address = mw ? wa : '0;
    res.mem_value   = mw ? wd : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_RESET;
      pc            <= START_RESET;
      stopped       <= 1'b0;
      clear_idx     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) start_address <= cfg_wdata;
      if (cmd.clear) clear_idx <= clear_idx + 1'b1;
      if (cmd.commit) begin
        pc        <= pc_next;
        stopped   <= stopped_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.decode) ir <= mem_word;
    if (cmd.commit) out_result <= res;
  end

  // Main memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clear_idx] <= '0;
    end else if (cmd.commit && mw) begin
      mem[wa[AW-1:0]] <= wd;
    end
    if (mem_ren) begin
      mem_q    <= mem[mem_raddr[AW-1:0]];
      mem_ok_q <= in_range(mem_raddr);
    end
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rf[clear_idx[REG_IDX_W-1:0]] <= '0;
    end else if (cmd.commit && rw) begin
      rf[ra] <= rv;
    end
    if (rf_ren) begin
      rf_a_q <= rf[rf_a_addr];
      rf_b_q <= rf[rf_b_addr];
    end
  end

endmodule

// ----- src/sixteen_bit_register_machine_core_unit.sv -----
// Reset clears memory and registers in one pass over the memory addresses; no item is taken meanwhile.
// One item at a time. Memory writes, reads, restart and halting steps commit from decode,
// executed instructions from execute, and loads from a further memory stage (extra memory port access).
// A new item can be taken in the cycle after the result is registered.
// The registered reads behind these steps: fetch, operand read at decode, and the load access.
// Reset sets the start address and program counter to 0x10 and clears the halted flag.
module sixteen_bit_register_machine_core_unit import srmc_pkg::*; #(
  parameter int MEMORY_WORDS = 256
) (
  input  logic              clk,
  input  logic              rst,
  srmc_stream_if.sink       in_ch,
  srmc_stream_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;
  result_t out_result;

  srmc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  srmc_datapath #(
    .MEMORY_WORDS (MEMORY_WORDS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_item    (in_ch.payload),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_result;

endmodule

// ----- src/srmc_checker.sv -----
// Port-level checker of the register machine core and its bind.
`include "sixteen_bit_register_machine_core_unit_macros.svh"

module srmc_checker import srmc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_payload
);

  // Items are worked one at a time, so the input closes right after an accept.
  `SRMC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

  // A counter at the last address always reports the machine as halted.
  `SRMC_ASSERT_IMPL(a_last_pc_halts,
                    out_valid && out_payload.pc_after == PC_LAST,
                    out_payload.halted,
                    "pc at last address but not halted")

  // Write reports carry zeros when no write took place.
  `SRMC_ASSERT_IMPL(a_quiet_writes,
                    out_valid && !out_payload.reg_written && !out_payload.mem_written,
                    out_payload.reg_index == '0 && out_payload.reg_value == '0 &&
                    out_payload.mem_address == '0 && out_payload.mem_value == '0,
                    "write fields set without a write")

  `SRMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind sixteen_bit_register_machine_core_unit srmc_checker u_srmc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

// ----- tb/sv/tb_sixteen_bit_register_machine_core_unit.sv -----
// Self-checking testbench for the register machine core: a directed program, then random ones.
module tb_sixteen_bit_register_machine_core_unit;
  import srmc_pkg::*;

  localparam int IDLE_PCT      = 18;
  localparam int RANDOM_ITEMS  = 750;
  localparam int HOLD_AT       = 200;
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_FROM    = 300;
  localparam int QUIET_TO      = 420;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RUN_LIMIT     = 2000000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  srmc_stream_if #(.payload_t(item_t))   in_ch ();
  srmc_stream_if #(.payload_t(result_t)) out_ch ();

  sixteen_bit_register_machine_core_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Machine state as the predictor sees it.
  logic [WORD_W-1:0] model_regs [REG_COUNT];
  logic [WORD_W-1:0] model_mem  [256];
  logic [ADDR_W-1:0] model_pc;
  logic              model_stopped;
  logic [ADDR_W-1:0] model_start;

  item_t   queued_items [$];
  result_t step_outcomes_due [$];

  int   items_queued;
  int   accepted_items;
  int   results_checked;
  int   instr_executed;
  int   start_settings;
  int   error_count;
  bit   offer_taken;
  bit   hold_done;
  int   hold_left;
  logic quiet_stretch;

  assign quiet_stretch = (accepted_items >= QUIET_FROM) && (accepted_items < QUIET_TO);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("sixteen_bit_register_machine_core_unit test failed");
    $finish;
  end

  // Applies one item to the machine state and returns the result it should produce.
  function automatic result_t machine_step(item_t it);
    result_t           r;
    logic [WORD_W-1:0] ins, rd, rs, rt, wv;
    logic signed [WORD_W-1:0] srs;
    logic [3:0]        op, d;
    logic [ADDR_W-1:0] nxt;
    logic              wr;
    r  = '0;
    wr = 1'b0;
    wv = '0;
    case (it.mode)
      MODE_WRITE: begin
        model_mem[it.address] = it.data;
        r.mem_written = 1'b1;
        r.mem_address = it.address;
        r.mem_value   = it.data;
      end
      MODE_EXEC: begin
        if (model_stopped || model_pc == PC_LAST) begin
          model_stopped = 1'b1;
        end else begin
          ins = model_mem[model_pc];
          op  = ins[15:12];
          d   = ins[11:8];
          if (op == OP_HALT) begin
            model_stopped = 1'b1;
          end else begin
            instr_executed++;
            rd  = model_regs[d];
            rs  = model_regs[ins[7:4]];
            rt  = model_regs[ins[3:0]];
            nxt = model_pc + 8'd1;
            case (op)
              OP_ADD: begin wr = 1'b1; wv = rs + rt; end
              OP_SUB: begin wr = 1'b1; wv = rs - rt; end
              OP_AND: begin wr = 1'b1; wv = rs & rt; end
              OP_XOR: begin wr = 1'b1; wv = rs ^ rt; end
              OP_SHL: begin
                wr = 1'b1;
                wv = (rt >= 16) ? '0 : rs << rt[3:0];
              end
              OP_SRA: begin
                wr = 1'b1;
                srs = rs;
                if (rt >= 16) wv = {WORD_W{rs[15]}};
                else wv = srs >>> rt[3:0];
              end
              OP_LDA:   begin wr = 1'b1; wv = {8'h00, ins[7:0]}; end
              OP_LOAD:  begin wr = 1'b1; wv = model_mem[ins[7:0]]; end
              OP_LOADI: begin wr = 1'b1; wv = model_mem[rt[7:0]]; end
              OP_STORE, OP_STOREI: begin
                r.mem_written = 1'b1;
                r.mem_address = (op == OP_STORE) ? ins[7:0] : rt[7:0];
                r.mem_value   = rd;
                model_mem[r.mem_address] = rd;
              end
              OP_BZ: if (rd == 0) nxt = ins[7:0];
              OP_BP: if (rd != 0 && !rd[15]) nxt = ins[7:0];
              OP_JR: nxt = rd[7:0];
              default: begin
                // Jump and link saves the incremented counter before jumping.
                wr  = 1'b1;
                wv  = {8'h00, nxt};
                nxt = ins[7:0];
              end
            endcase
            if (wr) begin
              model_regs[d] = wv;
              r.reg_written = 1'b1;
              r.reg_index   = d;
              r.reg_value   = wv;
            end
            model_pc = nxt;
            if (model_pc == PC_LAST) model_stopped = 1'b1;
          end
        end
      end
      MODE_READ_REG: r.read_data = (it.address < REG_COUNT) ? model_regs[it.address[3:0]] : '0;
      MODE_READ_MEM: r.read_data = model_mem[it.address];
      MODE_RESTART: begin
        model_pc      = model_start;
        model_stopped = (model_pc == PC_LAST);
      end
      default: ;
    endcase
    r.pc_after = model_pc;
    r.halted   = model_stopped;
    return r;
  endfunction

  // Random instruction; branch and link targets stay inside the program.
  function automatic logic [WORD_W-1:0] program_word(logic [ADDR_W-1:0] base, int len);
    logic [3:0]        op;
    logic [WORD_W-1:0] w;
    op = ($urandom_range(0, 24) == 0) ? OP_HALT : 4'($urandom_range(1, 15));
    w  = {op, 12'($urandom)};
    if (op == OP_BZ || op == OP_BP || op == OP_JAL) begin
      w[7:0] = base + 8'($urandom_range(0, len - 1));
    end else if (op == OP_LDA && $urandom_range(0, 1) == 0) begin
      w[7:0] = 8'($urandom_range(0, 20));
    end
    return w;
  endfunction

  task automatic queue_item(input logic [2:0] m, input logic [ADDR_W-1:0] a,
                            input logic [WORD_W-1:0] d);
    item_t it;
    it.mode    = m;
    it.address = a;
    it.data    = d;
    queued_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (queued_items.size() != 0 || step_outcomes_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_start(input logic [ADDR_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_start = v;
    start_settings++;
  endtask

  // Source side: offers the oldest queued item, with random gaps outside the quiet stretch.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || offer_taken) begin
      offer_taken = 1'b0;
      if (queued_items.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= queued_items[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      step_outcomes_due.push_back(machine_step(in_ch.payload));
      void'(queued_items.pop_front());
      accepted_items++;
      offer_taken = 1'b1;
    end
  end

  // Sink side: random stalls outside the quiet stretch, plus one long hold-off so the core backs up.
  // The hold starts only while items are still waiting, so the source keeps offering.
  always @(negedge clk) begin
    if (!hold_done && accepted_items >= HOLD_AT && queued_items.size() > 1) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (step_outcomes_due.size() == 0) begin
        $error("result arrived with no item outstanding");
        error_count++;
      end else begin
        want = step_outcomes_due.pop_front();
        check_field("read_data", want.read_data, out_ch.payload.read_data);
        check_field("pc_after", WORD_W'(want.pc_after),
                    WORD_W'(out_ch.payload.pc_after));
        check_field("halted", WORD_W'(want.halted), WORD_W'(out_ch.payload.halted));
        check_field("reg_written", WORD_W'(want.reg_written),
                    WORD_W'(out_ch.payload.reg_written));
        check_field("reg_index", WORD_W'(want.reg_index),
                    WORD_W'(out_ch.payload.reg_index));
        check_field("reg_value", want.reg_value, out_ch.payload.reg_value);
        check_field("mem_written", WORD_W'(want.mem_written),
                    WORD_W'(out_ch.payload.mem_written));
        check_field("mem_address", WORD_W'(want.mem_address),
                    WORD_W'(out_ch.payload.mem_address));
        check_field("mem_value", want.mem_value, out_ch.payload.mem_value);
        results_checked++;
      end
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] demo [20];
    int                directed_items;
    int                ep, plen, nexec, i;
    logic [ADDR_W-1:0] next_start;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = START_RESET;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    for (i = 0; i < REG_COUNT; i++) model_regs[i] = '0;
    for (i = 0; i < 256; i++) model_mem[i] = '0;
    model_start    = START_RESET;
    model_pc       = START_RESET;
    model_stopped  = 1'b0;
    start_settings = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program at the reset start address: every opcode, a negative
    // arithmetic shift, both branch outcomes, link, and a jump onto the last address.
    demo = '{16'h71FF, 16'h7204, 16'h5312, 16'h2501, 16'h6652, 16'h1731, 16'h3831,
             16'h4931, 16'h9780, 16'h8A80, 16'hB701, 16'hAB01, 16'hC01E, 16'h0000,
             16'hD520, 16'hD121, 16'h0000, 16'hFC23, 16'h0000, 16'hE100};
    queue_item(MODE_WRITE, 8'hFF, 16'hFFFF);
    queue_item(MODE_READ_MEM, 8'hFF, 16'h0000);
    for (i = 0; i < 20; i++) queue_item(MODE_WRITE, START_RESET + 8'(i), demo[i]);
    // The last step finds the core already stopped.
    for (i = 0; i < 18; i++) queue_item(MODE_EXEC, 8'h00, 16'h0000);
    queue_item(MODE_READ_REG, 8'h0B, 16'h0000);
    queue_item(MODE_READ_REG, 8'hFF, 16'hFFFF);
    queue_item(MODE_READ_MEM, 8'h80, 16'h0000);
    queue_item(3'd7, 8'hFF, 16'hFFFF);
    queue_item(MODE_RESTART, 8'h00, 16'h0000);
    directed_items = items_queued;

    // Random programs written at the start address and then stepped through.
    ep = 0;
    while (items_queued - directed_items < RANDOM_ITEMS) begin
      if (ep % 5 == 4) begin
        case (start_settings)
          1: next_start = PC_LAST;
          2: next_start = 8'h00;
          3: next_start = 8'hF8;
          4: next_start = START_RESET;
          default: next_start = 8'($urandom_range(0, 255));
        endcase
        set_start(next_start);
      end
      plen = $urandom_range(3, 12);
      // Now and then the restart is left out, so stepping resumes wherever it stopped.
      if ($urandom_range(0, 9) != 0) queue_item(MODE_RESTART, 8'($urandom), 16'($urandom));
      for (i = 0; i < plen; i++) begin
        queue_item(MODE_WRITE, model_start + 8'(i), program_word(model_start, plen));
      end
      if ($urandom_range(0, 1) == 0) queue_item(MODE_WRITE, 8'($urandom), 16'($urandom));
      nexec = plen + $urandom_range(0, 6);
      for (i = 0; i < nexec; i++) begin
        queue_item(MODE_EXEC, 8'($urandom), 16'($urandom));
        case ($urandom_range(0, 15))
          0: queue_item(MODE_READ_REG, 8'($urandom_range(0, 15)), 16'($urandom));
          1: queue_item(MODE_READ_MEM, 8'($urandom), 16'($urandom));
          2: queue_item(3'($urandom), 8'($urandom), 16'($urandom));
          3: queue_item(MODE_READ_REG, 8'($urandom), 16'($urandom));
          default: ;
        endcase
      end
      ep++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d items, %0d of them executing an instruction, under %0d start addresses.",
             accepted_items, instr_executed, start_settings);
    $display("Compared %0d results; %0d field mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("sixteen_bit_register_machine_core_unit test passed");
    end else begin
      $display("sixteen_bit_register_machine_core_unit test failed");
    end
    $finish;
  end

endmodule
